FILE: rtl/core/graph_walk_edge_classifier_macros.svh
// Assertion macros for the graph walk engine RTL.
// Included by graph_walk_edge_classifier, which checks its own sequencing.
`ifndef GRAPH_WALK_EDGE_CLASSIFIER_MACROS_SVH
`define GRAPH_WALK_EDGE_CLASSIFIER_MACROS_SVH

// Condition implies consequence in the same cycle.
`define GWEC_CHECK(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Condition implies consequence in the next cycle.
`define GWEC_CHECK_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/gwec_pkg.sv
// Package for the graph walk engine: payload structs, request and event codes.
// No dependencies; imported by graph_walk_edge_classifier.
`timescale 1ns / 1ps

package gwec_pkg;

    localparam int DEF_MAX_NODES = 64;
    localparam int DEF_MAX_EDGES = 256;
    localparam int CFG_W         = 7;

    localparam logic [1:0] REQ_ADD_EDGE = 2'd0;
    localparam logic [1:0] REQ_START_DF = 2'd1;
    localparam logic [1:0] REQ_START_BF = 2'd2;
    localparam logic [1:0] REQ_STEP     = 2'd3;

    localparam logic [3:0] EV_OK      = 4'd0;
    localparam logic [3:0] EV_REJECT  = 4'd1;
    localparam logic [3:0] EV_NEWTREE = 4'd2;
    localparam logic [3:0] EV_TREE    = 4'd3;
    localparam logic [3:0] EV_BACK    = 4'd4;
    localparam logic [3:0] EV_FORWARD = 4'd5;
    localparam logic [3:0] EV_CROSS   = 4'd6;
    localparam logic [3:0] EV_DISC    = 4'd7;
    localparam logic [3:0] EV_DONE    = 4'd8;
    localparam logic [3:0] EV_IDLE    = 4'd9;

    typedef struct packed {
        logic [1:0] req_type;
        logic [5:0] from_node;
        logic [5:0] to_node;
    } t_in_item;

    typedef struct packed {
        logic [3:0] event_kind;
        logic [5:0] edge_from;
        logic [5:0] edge_to;
        logic [7:0] edge_index;
        logic [7:0] from_disc_time;
        logic [7:0] to_finish_time;
    } t_out_item;

endpackage

FILE: rtl/core/graph_walk_edge_classifier.sv
// Graph walk engine top level: edge store, depth-first and breadth-first walker.
// Depends on gwec_pkg and graph_walk_edge_classifier_macros.svh.
//
//   channel   direction   handshake                    payload
//   in        to block    i_in_valid / o_in_stall      i_in_data  (t_in_item)
//   out       from block  o_out_valid / i_out_stall    o_out_data (t_out_item)
//   cfg       to block    i_cfg_valid / o_cfg_ready    i_cfg_data (node count)
//
// Every transfer on the input channel yields exactly one result transfer.
// A step may pass over skipped nodes of the new-tree scan, finished
// depth-first nodes and, in breadth-first mode, visited edges and queue pops
// before it reports its event. Every memory has a registered read port. Reset
// is synchronous and active low; the edge store, stack and queue memories need
// no clearing pass. A result stalled at the output holds the block, which takes
// no new item until that result is transferred.
`timescale 1ns / 1ps
`include "graph_walk_edge_classifier_macros.svh"

module graph_walk_edge_classifier #(
    parameter int MAX_NODES = gwec_pkg::DEF_MAX_NODES,
    parameter int MAX_EDGES = gwec_pkg::DEF_MAX_EDGES
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    input  gwec_pkg::t_in_item        i_in_data,
    output logic                      o_in_stall,
    output logic                      o_out_valid,
    output gwec_pkg::t_out_item       o_out_data,
    input  logic                      i_out_stall,
    input  logic                      i_cfg_valid,
    input  logic [gwec_pkg::CFG_W-1:0] i_cfg_data,
    output logic                      o_cfg_ready
);

    import gwec_pkg::*;

    // Node index, edge index, link (edge index or null) and level widths.
    localparam int NW  = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int EW  = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int LW  = $clog2(MAX_EDGES + 1);
    localparam int LVW = $clog2(MAX_NODES + 1);
    localparam logic [LW-1:0] NIL = LW'(MAX_EDGES);

    localparam logic [1:0] COLOR_WHITE = 2'd0;
    localparam logic [1:0] COLOR_GRAY  = 2'd1;
    localparam logic [1:0] COLOR_BLACK = 2'd2;

    typedef enum logic [1:0] {M_IDLE, M_DFS, M_BFS} t_mode;

    typedef enum logic [3:0] {
        S_IDLE, S_ADD, S_BST,
        D_CHK, D_SCAN, D_ENT, D_TOP, D_E1, D_E2, D_FIN,
        B_CHK, B_E1, B_E2, B_POP, B_HD
    } t_state;

    typedef struct packed {
        logic [1:0] color;
        logic [7:0] disc;
        logic [7:0] fin;
    } t_mark;

    typedef struct packed {
        logic [NW-1:0] src;
        logic [NW-1:0] tgt;
    } t_edge;

    typedef struct packed {
        logic [LW-1:0] head;
        logic [LW-1:0] tail;
    } t_list;

    typedef struct packed {
        logic [NW-1:0] node;
        logic [LW-1:0] cur;
    } t_frame;

    // Control and walk registers.
    t_state          r_state, n_state;
    t_mode           r_mode, n_mode;
    logic [CFG_W-1:0] r_node_count;
    logic [LW-1:0]   r_edges, n_edges;
    logic [7:0]      r_clock, n_clock;
    logic [LVW-1:0]  r_level, n_level;
    logic [LVW-1:0]  r_scan, n_scan;
    logic [LVW-1:0]  r_fhead, n_fhead;
    logic [LVW-1:0]  r_ftail, n_ftail;
    logic [NW-1:0]   r_bnode, n_bnode;
    logic [LW-1:0]   r_bcur, n_bcur;
    logic [NW-1:0]   r_u, n_u;
    logic [NW-1:0]   r_v, n_v;
    logic [LW-1:0]   r_c, n_c;
    logic [7:0]      r_td, n_td;
    t_out_item       r_out, n_out;
    logic            r_out_valid, n_out_valid;

    // Memories: edge endpoints, edge links, list head and tail, node marks,
    // the depth-first stack and the breadth-first queue.
    t_edge           edge_mem [MAX_EDGES];
    logic [LW-1:0]   link_mem [MAX_EDGES];
    t_list           list_mem [MAX_NODES];
    t_mark           mark_mem [MAX_NODES];
    t_frame          stack_mem [MAX_NODES];
    logic [NW-1:0]   fifo_mem [MAX_NODES];

    logic [MAX_NODES-1:0] r_list_vld;
    logic [MAX_NODES-1:0] r_mark_vld;

    logic            est_we;
    logic [EW-1:0]   est_wa;
    t_edge           est_wd;
    logic            enx_we;
    logic [EW-1:0]   enx_wa;
    logic [LW-1:0]   enx_wd;
    logic [EW-1:0]   edge_ra;
    t_edge           r_est_rd;
    logic [LW-1:0]   r_enx_rd;

    logic            lst_we;
    logic [NW-1:0]   lst_wa;
    t_list           lst_wd;
    logic [NW-1:0]   lst_ra;
    t_list           r_lst_rd;
    logic            r_lst_rv;
    t_list           lst_q;

    logic            mk_we;
    logic [NW-1:0]   mk_wa;
    t_mark           mk_wd;
    logic            mk_clr;
    logic [NW-1:0]   mk_ra;
    t_mark           r_mk_rd;
    logic            r_mk_rv;
    t_mark           mk_q;

    logic            sk_we;
    logic [NW-1:0]   sk_wa;
    t_frame          sk_wd;
    logic [NW-1:0]   sk_ra;
    t_frame          r_sk_rd;

    logic            ff_we;
    logic [NW-1:0]   ff_wa;
    logic [NW-1:0]   ff_wd;
    logic [NW-1:0]   ff_ra;
    logic [NW-1:0]   r_ff_rd;

    logic            in_acc;
    logic            from_ok;
    logic            to_ok;
    logic            scan_end;
    logic [LVW-1:0]  lvl_m1;
    logic [NW-1:0]   in_from;
    logic [NW-1:0]   in_to;
    logic [7:0]      clk_inc;

    assign o_in_stall  = (r_state != S_IDLE) || r_out_valid;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign o_cfg_ready = 1'b1;

    assign in_acc  = i_in_valid && !o_in_stall;
    assign in_from = NW'(i_in_data.from_node);
    assign in_to   = NW'(i_in_data.to_node);
    // A node is valid below both the configured count and the node capacity.
    assign from_ok = ({1'b0, i_in_data.from_node} < r_node_count)
                     && (32'(i_in_data.from_node) < MAX_NODES);
    assign to_ok   = ({1'b0, i_in_data.to_node} < r_node_count)
                     && (32'(i_in_data.to_node) < MAX_NODES);
    assign scan_end = (32'(r_scan) >= 32'(r_node_count)) || (32'(r_scan) >= MAX_NODES);
    assign lvl_m1  = r_level - LVW'(1);
    assign clk_inc = r_clock + 8'd1;

    // Lists unwritten since reset, and marks since walk start, read as cleared.
    always_comb begin
        lst_q = r_lst_rd;
        if (!r_lst_rv) begin
            lst_q.head = NIL;
            lst_q.tail = NIL;
        end
        mk_q = r_mk_rv ? r_mk_rd : '0;
    end

    always_comb begin
        n_state     = r_state;
        n_mode      = r_mode;
        n_edges     = r_edges;
        n_clock     = r_clock;
        n_level     = r_level;
        n_scan      = r_scan;
        n_fhead     = r_fhead;
        n_ftail     = r_ftail;
        n_bnode     = r_bnode;
        n_bcur      = r_bcur;
        n_u         = r_u;
        n_v         = r_v;
        n_c         = r_c;
        n_td        = r_td;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;

        est_we  = 1'b0;
        est_wa  = '0;
        est_wd  = '0;
        enx_we  = 1'b0;
        enx_wa  = '0;
        enx_wd  = '0;
        edge_ra = '0;
        lst_we  = 1'b0;
        lst_wa  = '0;
        lst_wd  = '0;
        lst_ra  = '0;
        mk_we   = 1'b0;
        mk_wa   = '0;
        mk_wd   = '0;
        mk_clr  = 1'b0;
        mk_ra   = '0;
        sk_we   = 1'b0;
        sk_wa   = '0;
        sk_wd   = '0;
        sk_ra   = '0;
        ff_we   = 1'b0;
        ff_wa   = '0;
        ff_wd   = '0;
        ff_ra   = '0;

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_out       = '0;
                    n_out_valid = 1'b1;
                    case (i_in_data.req_type)
                        REQ_ADD_EDGE: begin
                            if (!from_ok || !to_ok || (32'(r_edges) >= MAX_EDGES)) begin
                                n_out.event_kind = EV_REJECT;
                            end else begin
                                // The result is emitted once the list is linked.
                                n_out_valid = 1'b0;
                                n_u         = in_from;
                                n_v         = in_to;
                                lst_ra      = in_from;
                                est_we      = 1'b1;
                                est_wa      = r_edges[EW-1:0];
                                est_wd      = '{src: in_from, tgt: in_to};
                                enx_we      = 1'b1;
                                enx_wa      = r_edges[EW-1:0];
                                enx_wd      = NIL;
                                n_state     = S_ADD;
                            end
                        end
                        REQ_START_DF, REQ_START_BF: begin
                            if (!from_ok) begin
                                n_out.event_kind = EV_REJECT;
                            end else begin
                                n_out.event_kind = EV_OK;
                                mk_clr  = 1'b1;
                                n_clock = '0;
                                n_level = '0;
                                n_fhead = '0;
                                n_ftail = '0;
                                if (i_in_data.req_type == REQ_START_DF) begin
                                    n_mode = M_DFS;
                                    n_scan = LVW'(i_in_data.from_node);
                                end else begin
                                    n_mode      = M_BFS;
                                    mk_we       = 1'b1;
                                    mk_wa       = in_from;
                                    mk_wd       = '{color: COLOR_GRAY, disc: 8'd0, fin: 8'd0};
                                    n_bnode     = in_from;
                                    lst_ra      = in_from;
                                    n_out_valid = 1'b0;
                                    n_state     = S_BST;
                                end
                            end
                        end
                        REQ_STEP: begin
                            if (r_mode == M_DFS) begin
                                n_out_valid = 1'b0;
                                n_state     = D_CHK;
                            end else if (r_mode == M_BFS) begin
                                n_out_valid = 1'b0;
                                n_state     = B_CHK;
                            end else begin
                                n_out.event_kind = EV_IDLE;
                            end
                        end
                        default: begin
                            n_out.event_kind = EV_IDLE;
                        end
                    endcase
                end
            end

            S_ADD: begin
                // Append to the source's list; an empty list gets a new head.
                lst_we = 1'b1;
                lst_wa = r_u;
                lst_wd = '{head: lst_q.head, tail: r_edges};
                if (lst_q.tail == NIL) begin
                    lst_wd.head = r_edges;
                end else begin
                    enx_we = 1'b1;
                    enx_wa = lst_q.tail[EW-1:0];
                    enx_wd = r_edges;
                end
                n_edges           = r_edges + LW'(1);
                n_out             = '0;
                n_out.event_kind  = EV_OK;
                n_out.edge_from   = 6'(r_u);
                n_out.edge_to     = 6'(r_v);
                n_out.edge_index  = 8'(r_edges);
                n_out_valid       = 1'b1;
                n_state           = S_IDLE;
            end

            S_BST: begin
                n_bcur           = lst_q.head;
                n_out            = '0;
                n_out.event_kind = EV_OK;
                n_out_valid      = 1'b1;
                n_state          = S_IDLE;
            end

            D_CHK: begin
                if (r_level != '0) begin
                    sk_ra   = lvl_m1[NW-1:0];
                    n_state = D_TOP;
                end else if (scan_end) begin
                    n_mode           = M_IDLE;
                    n_out            = '0;
                    n_out.event_kind = EV_DONE;
                    n_out_valid      = 1'b1;
                    n_state          = S_IDLE;
                end else begin
                    mk_ra   = r_scan[NW-1:0];
                    n_state = D_SCAN;
                end
            end

            D_SCAN: begin
                n_scan = r_scan + LVW'(1);
                if (mk_q.color == COLOR_WHITE) begin
                    n_out            = '0;
                    n_out.event_kind = EV_NEWTREE;
                    n_out.edge_from  = 6'(r_scan[NW-1:0]);
                    n_out_valid      = 1'b1;
                    n_clock          = clk_inc;
                    mk_we            = 1'b1;
                    mk_wa            = r_scan[NW-1:0];
                    mk_wd            = '{color: COLOR_GRAY, disc: clk_inc, fin: 8'd0};
                    lst_ra           = r_scan[NW-1:0];
                    n_u              = r_scan[NW-1:0];
                    n_state          = D_ENT;
                end else begin
                    n_state = D_CHK;
                end
            end

            D_ENT: begin
                // Push the newly discovered node with its list head as cursor.
                if (32'(r_level) < MAX_NODES) begin
                    sk_we   = 1'b1;
                    sk_wa   = r_level[NW-1:0];
                    sk_wd   = '{node: r_u, cur: lst_q.head};
                    n_level = r_level + LVW'(1);
                end
                n_state = S_IDLE;
            end

            D_TOP: begin
                n_u   = r_sk_rd.node;
                n_c   = r_sk_rd.cur;
                mk_ra = r_sk_rd.node;
                if (r_sk_rd.cur < NIL) begin
                    edge_ra = r_sk_rd.cur[EW-1:0];
                    n_state = D_E1;
                end else begin
                    n_state = D_FIN;
                end
            end

            D_E1: begin
                sk_we   = 1'b1;
                sk_wa   = lvl_m1[NW-1:0];
                sk_wd   = '{node: r_u, cur: r_enx_rd};
                n_td    = mk_q.disc;
                n_v     = r_est_rd.tgt;
                mk_ra   = r_est_rd.tgt;
                n_state = D_E2;
            end

            D_E2: begin
                n_out                = '0;
                n_out.edge_from      = 6'(r_u);
                n_out.edge_to        = 6'(r_v);
                n_out.edge_index     = 8'(r_c);
                n_out.from_disc_time = r_td;
                n_out.to_finish_time = mk_q.fin;
                n_out_valid          = 1'b1;
                n_state              = S_IDLE;
                if (mk_q.color == COLOR_WHITE) begin
                    n_out.event_kind = EV_TREE;
                    n_clock          = clk_inc;
                    mk_we            = 1'b1;
                    mk_wa            = r_v;
                    mk_wd            = '{color: COLOR_GRAY, disc: clk_inc, fin: 8'd0};
                    lst_ra           = r_v;
                    n_u              = r_v;
                    n_state          = D_ENT;
                end else if (mk_q.color == COLOR_GRAY) begin
                    n_out.event_kind = EV_BACK;
                end else if (r_td < mk_q.disc) begin
                    n_out.event_kind = EV_FORWARD;
                end else begin
                    n_out.event_kind = EV_CROSS;
                end
            end

            D_FIN: begin
                // Adjacency list exhausted: finish the node and pop it.
                n_clock = clk_inc;
                mk_we   = 1'b1;
                mk_wa   = r_u;
                mk_wd   = '{color: COLOR_BLACK, disc: mk_q.disc, fin: clk_inc};
                n_level = lvl_m1;
                n_state = D_CHK;
            end

            B_CHK: begin
                if (r_bcur < NIL) begin
                    edge_ra = r_bcur[EW-1:0];
                    n_c     = r_bcur;
                    n_state = B_E1;
                end else begin
                    mk_we = 1'b1;
                    mk_wa = r_bnode;
                    mk_wd = '{color: COLOR_BLACK, disc: 8'd0, fin: 8'd0};
                    if (r_fhead < r_ftail) begin
                        ff_ra   = r_fhead[NW-1:0];
                        n_state = B_POP;
                    end else begin
                        n_mode           = M_IDLE;
                        n_out            = '0;
                        n_out.event_kind = EV_DONE;
                        n_out_valid      = 1'b1;
                        n_state          = S_IDLE;
                    end
                end
            end

            B_E1: begin
                n_bcur  = r_enx_rd;
                n_u     = r_est_rd.src;
                n_v     = r_est_rd.tgt;
                mk_ra   = r_est_rd.tgt;
                n_state = B_E2;
            end

            B_E2: begin
                if (mk_q.color == COLOR_WHITE) begin
                    mk_we = 1'b1;
                    mk_wa = r_v;
                    mk_wd = '{color: COLOR_GRAY, disc: 8'd0, fin: 8'd0};
                    if (32'(r_ftail) < MAX_NODES) begin
                        ff_we   = 1'b1;
                        ff_wa   = r_ftail[NW-1:0];
                        ff_wd   = r_v;
                        n_ftail = r_ftail + LVW'(1);
                    end
                    n_out            = '0;
                    n_out.event_kind = EV_DISC;
                    n_out.edge_from  = 6'(r_u);
                    n_out.edge_to    = 6'(r_v);
                    n_out.edge_index = 8'(r_c);
                    n_out_valid      = 1'b1;
                    n_state          = S_IDLE;
                end else begin
                    n_state = B_CHK;
                end
            end

            B_POP: begin
                n_bnode = r_ff_rd;
                n_fhead = r_fhead + LVW'(1);
                lst_ra  = r_ff_rd;
                n_state = B_HD;
            end

            B_HD: begin
                n_bcur  = lst_q.head;
                n_state = B_CHK;
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_mode      <= M_IDLE;
            r_edges     <= '0;
            r_clock     <= '0;
            r_level     <= '0;
            r_scan      <= '0;
            r_fhead     <= '0;
            r_ftail     <= '0;
            r_bnode     <= '0;
            r_bcur      <= NIL;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_mode      <= n_mode;
            r_edges     <= n_edges;
            r_clock     <= n_clock;
            r_level     <= n_level;
            r_scan      <= n_scan;
            r_fhead     <= n_fhead;
            r_ftail     <= n_ftail;
            r_bnode     <= n_bnode;
            r_bcur      <= n_bcur;
            r_out_valid <= n_out_valid;
        end
    end

    // Working registers and the result payload carry no reset.
    always_ff @(posedge i_clk) begin
        r_u   <= n_u;
        r_v   <= n_v;
        r_c   <= n_c;
        r_td  <= n_td;
        r_out <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_node_count <= i_cfg_data;
        end
    end

    // List valid bits stand for the null reset of the head and tail table.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_list_vld <= '0;
        end else if (lst_we) begin
            r_list_vld[lst_wa] <= 1'b1;
        end
    end

    // Mark valid bits clear every node to white at a walk start.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mark_vld <= '0;
        end else begin
            if (mk_clr) begin
                r_mark_vld <= '0;
            end
            if (mk_we) begin
                r_mark_vld[mk_wa] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (est_we) begin
            edge_mem[est_wa] <= est_wd;
        end
        if (enx_we) begin
            link_mem[enx_wa] <= enx_wd;
        end
        r_est_rd <= edge_mem[edge_ra];
        r_enx_rd <= link_mem[edge_ra];
    end

    always_ff @(posedge i_clk) begin
        if (lst_we) begin
            list_mem[lst_wa] <= lst_wd;
        end
        r_lst_rd <= list_mem[lst_ra];
        r_lst_rv <= r_list_vld[lst_ra];
    end

    always_ff @(posedge i_clk) begin
        if (mk_we) begin
            mark_mem[mk_wa] <= mk_wd;
        end
        r_mk_rd <= mark_mem[mk_ra];
        r_mk_rv <= r_mark_vld[mk_ra];
    end

    always_ff @(posedge i_clk) begin
        if (sk_we) begin
            stack_mem[sk_wa] <= sk_wd;
        end
        r_sk_rd <= stack_mem[sk_ra];
    end

    always_ff @(posedge i_clk) begin
        if (ff_we) begin
            fifo_mem[ff_wa] <= ff_wd;
        end
        r_ff_rd <= fifo_mem[ff_ra];
    end

    `GWEC_CHECK(a_level_bound, i_clk, i_rst_n, 1'b1, (32'(r_level) <= MAX_NODES), "stack overflow")
    `GWEC_CHECK(a_fifo_order, i_clk, i_rst_n, 1'b1, (r_fhead <= r_ftail), "queue underflow")
    `GWEC_CHECK(a_dfs_mode, i_clk, i_rst_n, (r_state == D_CHK), (r_mode == M_DFS), "dfs state out of mode")
    `GWEC_CHECK_NEXT(a_item_busy, i_clk, i_rst_n, in_acc, ((r_state != S_IDLE) || r_out_valid), "item dropped")

endmodule
